// ===== rtl/tff_pkg.sv =====
// ---------------------------------------------------------------------------
// tff_pkg: shared types and constants for the tangent frame pipeline
// Widths of the datapath and the per-component state of the root search.
// ---------------------------------------------------------------------------
package tff_pkg;

  // input component width (signed)
  localparam int CB    = 16;
  // output format
  localparam int OW    = 16;
  localparam int FRAC  = 14;
  // quotient bits searched, one per step stage
  localparam int QW    = FRAC + 1;
  // magnitude products and their squares
  localparam int PW    = 2 * CB;
  localparam int SQW   = 4 * CB;
  localparam int SW    = SQW + 2;
  // search residue width, room for s * 2^(2*QW+4)
  localparam int RW    = SQW + 2 * QW + 6;
  // initial shifts for the top search bit k = QW-1
  localparam int VSH   = 2 * FRAC + 2;
  localparam int ASH   = QW + 1;
  localparam int BSH   = 2 * QW;
  // front end register stages
  localparam int FRONT = 5;

  // one vector component in flight through the root search
  typedef struct packed {
    logic signed [RW-1:0] r;   // m^2 * 2^30 - u^2 * s
    logic signed [RW-1:0] a;   // u * s * 2^(k+2)
    logic signed [RW-1:0] b;   // s * 2^(2k+2)
    logic [QW-1:0]        q;   // quotient bits found so far
    logic                 neg; // sign of the component
  } root_t;

endpackage

// ===== rtl/tff_front.sv =====
// ---------------------------------------------------------------------------
// tff_front: frame direction and search setup
// Five register stages: sign split, products, candidate select, squares,
// length sums and search initialization for six components.
// ---------------------------------------------------------------------------
module tff_front (
  input  logic                         clk,
  input  logic                         en,
  input  logic signed [tff_pkg::CB-1:0] normal_x,
  input  logic signed [tff_pkg::CB-1:0] normal_y,
  input  logic signed [tff_pkg::CB-1:0] normal_z,
  output tff_pkg::root_t               init [6],
  output logic                         degenerate
);
  import tff_pkg::*;

  // stage 1: sign and magnitude
  logic [CB-1:0] mx_r, my_r, mz_r;
  logic          sx_r, sy_r, sz_r;
  // stage 2: products
  logic [PW-1:0] pxz_r, pyz_r, pxx_r, pyy_r, pxy_r, pzz_r;
  logic [CB-1:0] mx2_r, my2_r, mz2_r;
  logic          sx2_r, sy2_r, sz2_r, sel_r, deg2_r;
  // stage 3: tangent and bitangent directions
  logic [PW-1:0] m3_r [6];
  logic          n3_r [6];
  logic          deg3_r;
  // stage 4: squares
  logic [SQW-1:0] sq4_r [6];
  logic           n4_r [6];
  logic           deg4_r;
  // stage 5: search start
  root_t          init_r [6];
  logic           deg5_r;

  logic [CB-1:0]  ax, ay, az;

  // magnitudes of two's complement inputs (most negative fits unsigned)
  always_comb begin
    ax = normal_x[CB-1] ? (~normal_x + 1'b1) : normal_x;
    ay = normal_y[CB-1] ? (~normal_y + 1'b1) : normal_y;
    az = normal_z[CB-1] ? (~normal_z + 1'b1) : normal_z;
  end

  always_ff @(posedge clk) begin
    if (en) begin
      mx_r <= ax;
      my_r <= ay;
      mz_r <= az;
      sx_r <= normal_x[CB-1];
      sy_r <= normal_y[CB-1];
      sz_r <= normal_z[CB-1];
    end
  end

  // pairwise products and candidate choice
  always_ff @(posedge clk) begin
    if (en) begin
      pxz_r  <= PW'(mx_r) * PW'(mz_r);
      pyz_r  <= PW'(my_r) * PW'(mz_r);
      pxx_r  <= PW'(mx_r) * PW'(mx_r);
      pyy_r  <= PW'(my_r) * PW'(my_r);
      pxy_r  <= PW'(mx_r) * PW'(my_r);
      pzz_r  <= PW'(mz_r) * PW'(mz_r);
      mx2_r  <= mx_r;
      my2_r  <= my_r;
      mz2_r  <= mz_r;
      sx2_r  <= sx_r;
      sy2_r  <= sy_r;
      sz2_r  <= sz_r;
      sel_r  <= (my_r > mz_r);
      deg2_r <= (mx_r == '0) && (my_r == '0) && (mz_r == '0);
    end
  end

  // t = n x Z or n x Y; b = n x t
  always_ff @(posedge clk) begin
    if (en) begin
      if (sel_r) begin
        m3_r[0] <= PW'(my2_r);
        m3_r[1] <= PW'(mx2_r);
        m3_r[2] <= '0;
        n3_r[0] <= sy2_r;
        n3_r[1] <= !sx2_r && (mx2_r != '0);
        n3_r[2] <= 1'b0;
        m3_r[3] <= pxz_r;
        m3_r[4] <= pyz_r;
        m3_r[5] <= pxx_r + pyy_r;
        n3_r[3] <= sx2_r ^ sz2_r;
        n3_r[4] <= sy2_r ^ sz2_r;
        n3_r[5] <= 1'b1;
      end else begin
        m3_r[0] <= PW'(mz2_r);
        m3_r[1] <= '0;
        m3_r[2] <= PW'(mx2_r);
        n3_r[0] <= !sz2_r && (mz2_r != '0);
        n3_r[1] <= 1'b0;
        n3_r[2] <= sx2_r;
        m3_r[3] <= pxy_r;
        m3_r[4] <= pxx_r + pzz_r;
        m3_r[5] <= pyz_r;
        n3_r[3] <= sx2_r ^ sy2_r;
        n3_r[4] <= 1'b1;
        n3_r[5] <= sy2_r ^ sz2_r;
      end
      deg3_r <= deg2_r;
    end
  end

  // component squares
  always_ff @(posedge clk) begin
    if (en) begin
      for (int i = 0; i < 6; i++) begin
        sq4_r[i] <= SQW'(m3_r[i]) * SQW'(m3_r[i]);
        n4_r[i]  <= n3_r[i];
      end
      deg4_r <= deg3_r;
    end
  end

  // squared lengths and search state for the top quotient bit
  logic [SW-1:0] len_t, len_b;
  always_comb begin
    len_t = SW'(sq4_r[0]) + SW'(sq4_r[1]) + SW'(sq4_r[2]);
    len_b = SW'(sq4_r[3]) + SW'(sq4_r[4]) + SW'(sq4_r[5]);
  end

  always_ff @(posedge clk) begin
    if (en) begin
      for (int i = 0; i < 6; i++) begin
        init_r[i].r   <= (signed'(RW'(sq4_r[i])) <<< VSH)
                         - signed'(RW'((i < 3) ? len_t : len_b));
        init_r[i].a   <= -(signed'(RW'((i < 3) ? len_t : len_b)) <<< ASH);
        init_r[i].b   <= signed'(RW'((i < 3) ? len_t : len_b)) <<< BSH;
        init_r[i].q   <= '0;
        init_r[i].neg <= n4_r[i];
      end
      deg5_r <= deg4_r;
    end
  end

  assign init       = init_r;
  assign degenerate = deg5_r;

endmodule

// ===== rtl/tff_root_step.sv =====
// ---------------------------------------------------------------------------
// tff_root_step: one bit of the rounded m * 2^14 / sqrt(s) search
// Tries the next quotient bit; keeps the residue exact with shifts and adds.
// ---------------------------------------------------------------------------
module tff_root_step (
  input  logic           clk,
  input  logic           en,
  input  tff_pkg::root_t d,
  output tff_pkg::root_t q
);
  import tff_pkg::*;

  root_t                st_r;
  root_t                st_nxt;
  logic signed [RW-1:0] trial;
  logic                 take;

  // residue after setting this bit; keep it when non-negative
  always_comb begin
    trial         = d.r - d.a - d.b;
    take          = !trial[RW-1];
    st_nxt.r      = take ? trial : d.r;
    st_nxt.a      = (take ? (d.a + (d.b <<< 1)) : d.a) >>> 1;
    st_nxt.b      = d.b >>> 2;
    st_nxt.q      = {d.q[QW-2:0], take};
    st_nxt.neg    = d.neg;
  end

  always_ff @(posedge clk) begin
    if (en) begin
      st_r <= st_nxt;
    end
  end

  assign q = st_r;

endmodule

// ===== rtl/tangent_frame_from_normal.sv =====
// ---------------------------------------------------------------------------
// tangent_frame_from_normal: unit tangent and bitangent from a normal
// Streams one normal per cycle through the pipeline unless out_stall holds it.
// ---------------------------------------------------------------------------
// Usage:
//   Input channel in_*: a signed normal (x, y, z). A transfer happens when
//   in_valid is high and in_stall is low.
//   Output channel out_*: unit tangent and bitangent in signed Q1.14, plus
//   out_degenerate for a zero normal (all vector fields then zero).
//   The data passes 21 register stages (5 front-end, 15 quotient-bit
//   search, 1 output register), the first loaded at the transfer edge;
//   out_valid travels with the data through the same stages.
//   Throughput: one normal per cycle unless out_stall holds the pipeline;
//   each search stage resolves one bit of every component, setting the depth.
//   Reset (rst_n low, synchronous) clears all valid bits; no item is lost
//   or produced by reset beyond dropping what was in flight.
//   When out_stall is high with a result waiting, the whole pipeline holds
//   and in_stall rises in the same cycle; nothing is dropped or repeated.
// ---------------------------------------------------------------------------
module tangent_frame_from_normal (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          in_valid,
  output logic                          in_stall,
  input  logic signed [tff_pkg::CB-1:0] in_normal_x,
  input  logic signed [tff_pkg::CB-1:0] in_normal_y,
  input  logic signed [tff_pkg::CB-1:0] in_normal_z,
  output logic                          out_valid,
  input  logic                          out_stall,
  output logic signed [tff_pkg::OW-1:0] out_tangent_x,
  output logic signed [tff_pkg::OW-1:0] out_tangent_y,
  output logic signed [tff_pkg::OW-1:0] out_tangent_z,
  output logic signed [tff_pkg::OW-1:0] out_bitangent_x,
  output logic signed [tff_pkg::OW-1:0] out_bitangent_y,
  output logic signed [tff_pkg::OW-1:0] out_bitangent_z,
  output logic                          out_degenerate
);
  import tff_pkg::*;

  localparam int DEPTH = FRONT + QW + 1;

  logic [DEPTH-1:0] vld_r;
  logic             adv;
  root_t            stg [QW+1][6];
  logic             deg_front;
  logic [QW-1:0]    deg_r;
  logic [OW-1:0]    res_r [6];
  logic             odeg_r;

  // global hold while the output register is full and stalled
  assign adv      = !(vld_r[DEPTH-1] && out_stall);
  assign in_stall = !adv;

  // valid bits travel with the data
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= '0;
    end else if (adv) begin
      vld_r <= {vld_r[DEPTH-2:0], in_valid};
    end
  end

  tff_front u_front (
    .clk        (clk),
    .en         (adv),
    .normal_x   (in_normal_x),
    .normal_y   (in_normal_y),
    .normal_z   (in_normal_z),
    .init       (stg[0]),
    .degenerate (deg_front)
  );

  // one quotient bit per stage, six components in parallel
  for (genvar j = 0; j < QW; j++) begin : g_step
    for (genvar c = 0; c < 6; c++) begin : g_comp
      tff_root_step u_step (
        .clk (clk),
        .en  (adv),
        .d   (stg[j][c]),
        .q   (stg[j+1][c])
      );
    end
  end

  // degenerate flag alongside the search stages
  always_ff @(posedge clk) begin
    if (adv) begin
      deg_r <= {deg_r[QW-2:0], deg_front};
    end
  end

  // apply signs, force zero for a zero normal
  always_ff @(posedge clk) begin
    if (adv) begin
      for (int i = 0; i < 6; i++) begin
        if (deg_r[QW-1]) begin
          res_r[i] <= '0;
        end else if (stg[QW][i].neg) begin
          res_r[i] <= ~OW'(stg[QW][i].q) + 1'b1;
        end else begin
          res_r[i] <= OW'(stg[QW][i].q);
        end
      end
      odeg_r <= deg_r[QW-1];
    end
  end

  assign out_valid       = vld_r[DEPTH-1];
  assign out_tangent_x   = signed'(res_r[0]);
  assign out_tangent_y   = signed'(res_r[1]);
  assign out_tangent_z   = signed'(res_r[2]);
  assign out_bitangent_x = signed'(res_r[3]);
  assign out_bitangent_y = signed'(res_r[4]);
  assign out_bitangent_z = signed'(res_r[5]);
  assign out_degenerate  = odeg_r;

endmodule
